[hdl/kvt_pkg.sv]
// Shared constants, codes and types for the keyed value table.
`default_nettype none
package kvt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 48;

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

endpackage
`default_nettype wire

[hdl/kvt_mem.sv]
// Entry store: one write port, one registered read port.
`default_nettype none
module kvt_mem
    import kvt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_entry        o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule
`default_nettype wire

[hdl/keyed_value_table.sv]
// Top level: insertion-ordered key/value table with linear search over one memory.
// Insert, clear and unknown actions complete without a scan; lookup, count and erase read the
// entries one by one. A lookup stops at the first match; an erase hit shifts later entries down.
// One item at a time, set by the single memory read port.
// Reset (synchronous, active low) empties the table; memory contents are not cleared.
`default_nettype none
module keyed_value_table
    import kvt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // lookup_key[31:0], value_in[63:32]
    input  wire logic [ACT_W-1:0]      s_axis_tuser,  // action[2:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // status[1:0], found[2], value_out[34:3],
                                                      // match_count[40:35], table_size[46:41]
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic [ACT_W-1:0]        r_act, n_act;
    logic [KEY_WIDTH-1:0]    r_key, n_key;
    logic [VALUE_WIDTH-1:0]  r_val, n_val;
    logic [STAT_W-1:0]       r_status, n_status;
    logic                    r_found, n_found;
    logic [VALUE_WIDTH-1:0]  r_vout, n_vout;
    logic [CNT_W-1:0]        r_mcount, n_mcount;
    logic                    r_out_vld, n_out_vld;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;

    t_mem_req                mem_req;
    t_entry                  rd_data;
    logic                    issue;
    logic                    key_hit;
    logic                    val_hit;

    kvt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign issue   = (r_idx < r_count);
    assign key_hit = (rd_data.key == r_key);
    assign val_hit = (rd_data.value == r_val);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_act      = r_act;
        n_key      = r_key;
        n_val      = r_val;
        n_status   = r_status;
        n_found    = r_found;
        n_vout     = r_vout;
        n_mcount   = r_mcount;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_count[IDX_W-1:0];
        mem_req.wr_data = '{key: s_axis_tdata[KEY_WIDTH-1:0],
                            value: s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH]};
        mem_req.rd_addr = r_idx[IDX_W-1:0];

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act    = s_axis_tuser;
                    n_key    = s_axis_tdata[KEY_WIDTH-1:0];
                    n_val    = s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH];
                    n_status = ST_DONE;
                    n_found  = 1'b0;
                    n_vout   = '0;
                    n_mcount = '0;
                    n_idx    = '0;
                    unique case (s_axis_tuser) inside
                        ACT_INSERT: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_req.wr_en = 1'b1;
                                n_count       = r_count + CNT_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        ACT_ERASE, ACT_LOOKUP, ACT_COUNT: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    if (r_act == ACT_COUNT && val_hit) begin
                        n_mcount = r_mcount + CNT_W'(1);
                    end
                    if (r_act == ACT_LOOKUP && key_hit) begin
                        n_found  = 1'b1;
                        n_vout   = rd_data.value;
                        n_rd_vld = 1'b0;
                        n_state  = S_DONE;
                    end
                    if (r_act == ACT_ERASE && key_hit) begin
                        // restart reads just past the match for the shift-down
                        n_found  = 1'b1;
                        n_idx    = CNT_W'(r_rd_idx) + CNT_W'(1);
                        n_rd_vld = 1'b0;
                        n_state  = S_SHIFT;
                    end
                end else if (!issue) begin
                    if (r_act != ACT_COUNT) begin
                        n_status = ST_MISSING;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (issue) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_rd_idx - IDX_W'(1);
                    mem_req.wr_data = rd_data;
                end else if (!issue) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {1'b0, r_count, r_mcount, r_vout, r_found, r_status};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_act      <= n_act;
        r_key      <= n_key;
        r_val      <= n_val;
        r_status   <= n_status;
        r_found    <= n_found;
        r_vout     <= n_vout;
        r_mcount   <= n_mcount;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

[hdl/kvt_checker.sv]
// Port-level checks on the keyed value table results, bound to the top level.
`default_nettype none
module kvt_checker
    import kvt_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0]      c_status;
    logic                   c_found;
    logic [VALUE_WIDTH-1:0] c_vout;
    logic [CNT_W-1:0]       c_mcount;
    logic [CNT_W-1:0]       c_size;

    assign c_status = m_axis_tdata[1:0];
    assign c_found  = m_axis_tdata[2];
    assign c_vout   = m_axis_tdata[34:3];
    assign c_mcount = m_axis_tdata[40:35];
    assign c_size   = m_axis_tdata[46:41];

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (c_size <= CNT_W'(TABLE_DEPTH)))
        else $error("table size beyond depth");

    a_full_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && c_status == ST_FULL) |-> (c_size == CNT_W'(TABLE_DEPTH)))
        else $error("full status with room left");

    a_missing_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && c_status == ST_MISSING) |-> (!c_found && c_vout == '0))
        else $error("missing key with found or value set");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (c_mcount <= c_size))
        else $error("match count beyond table size");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind keyed_value_table kvt_checker u_kvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[sim/keyed_value_table_tb.sv]
// Self-checking testbench for keyed_value_table: directed table, then random traffic.
module keyed_value_table_tb;
    import kvt_pkg::*;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 1028;
    localparam int CALM_TAIL  = 80;
    localparam int PHASE_LEN  = 48;
    localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic                   found;
        logic [VALUE_WIDTH-1:0] value_out;
        logic [CNT_W-1:0]       match_count;
        logic [CNT_W-1:0]       table_size;
    } t_result;

    typedef struct packed {
        logic [ACT_W-1:0]       act;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
        logic                   typed;
        t_result                res;
    } t_stim;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // lookup_key[31:0], value_in[63:32]
    logic [ACT_W-1:0]       s_axis_tuser;   // action[2:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // status[1:0], found[2], value_out[34:3],
                                            // match_count[40:35], table_size[46:41]

    logic [KEY_WIDTH-1:0]   key_mirror [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] val_mirror [TABLE_DEPTH];
    int                     held;
    t_result                expected_results [$];
    t_stim                  directed [N_DIRECTED];
    logic [KEY_WIDTH-1:0]   key_pool [8];
    logic [VALUE_WIDTH-1:0] val_pool [6];
    int                     mismatches = 0;
    int                     stall_left = 0;
    bit                     calm = 1'b0;

    keyed_value_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Applies one action to the mirrored table and returns what the block should report.
    function automatic t_result table_apply(input logic [ACT_W-1:0] act,
                                            input logic [KEY_WIDTH-1:0] key,
                                            input logic [VALUE_WIDTH-1:0] val);
        t_result r;
        int      hit;
        r   = '0;
        hit = -1;
        if (act == ACT_ERASE || act == ACT_LOOKUP) begin
            for (int i = 0; i < held; i++) begin
                if (hit < 0 && key_mirror[i] == key) begin
                    hit = i;
                end
            end
        end
        case (act)
            ACT_INSERT: begin
                if (held >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    key_mirror[held] = key;
                    val_mirror[held] = val;
                    held++;
                end
            end
            ACT_ERASE: begin
                if (hit < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int i = hit + 1; i < held; i++) begin
                        key_mirror[i-1] = key_mirror[i];
                        val_mirror[i-1] = val_mirror[i];
                    end
                    held--;
                    r.found = 1'b1;
                end
            end
            ACT_CLEAR: begin
                held = 0;
            end
            ACT_LOOKUP: begin
                if (hit < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.found     = 1'b1;
                    r.value_out = val_mirror[hit];
                end
            end
            ACT_COUNT: begin
                for (int i = 0; i < held; i++) begin
                    if (val_mirror[i] == val) begin
                        r.match_count = r.match_count + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
        r.table_size = CNT_W'(held);
        return r;
    endfunction

    function automatic t_stim stim_row(input logic [ACT_W-1:0] act,
                                       input logic [KEY_WIDTH-1:0] key,
                                       input logic [VALUE_WIDTH-1:0] val,
                                       input logic typed,
                                       input logic [STAT_W-1:0] status,
                                       input logic found,
                                       input logic [VALUE_WIDTH-1:0] vout,
                                       input int mcount,
                                       input int size);
        t_stim s;
        s.act             = act;
        s.key             = key;
        s.val             = val;
        s.typed           = typed;
        s.res.status      = status;
        s.res.found       = found;
        s.res.value_out   = vout;
        s.res.match_count = CNT_W'(mcount);
        s.res.table_size  = CNT_W'(size);
        return s;
    endfunction

    task automatic send_item(input t_stim s);
        t_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.val, s.key};
        s_axis_tuser  <= s.act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = table_apply(s.act, s.key, s.val);
        expected_results.push_back(s.typed ? s.res : predicted);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // result side: check, then decide the ready for the next cycle
    always @(posedge i_clk) begin : rx
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status      = m_axis_tdata[1:0];
            got.found       = m_axis_tdata[2];
            got.value_out   = m_axis_tdata[34:3];
            got.match_count = m_axis_tdata[40:35];
            got.table_size  = m_axis_tdata[46:41];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("value_out", want.value_out, got.value_out);
                check_field("match_count", 32'(want.match_count), 32'(got.match_count));
                check_field("table_size", 32'(want.table_size), 32'(got.table_size));
            end
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        t_stim s;
        t_mix  mix;
        int    pick;
        held = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_INSERT;

        directed[0]  = stim_row(ACT_LOOKUP, '0, '0, 1, ST_MISSING, 0, '0, 0, 0);
        directed[1]  = stim_row(ACT_ERASE, '1, '0, 1, ST_MISSING, 0, '0, 0, 0);
        directed[2]  = stim_row(ACT_COUNT, '0, '0, 1, ST_DONE, 0, '0, 0, 0);
        directed[3]  = stim_row(ACT_INSERT, '1, '0, 1, ST_DONE, 0, '0, 0, 1);
        directed[4]  = stim_row(ACT_INSERT, '0, '1, 1, ST_DONE, 0, '0, 0, 2);
        directed[5]  = stim_row(ACT_LOOKUP, '1, '0, 1, ST_DONE, 1, '0, 0, 2);
        directed[6]  = stim_row(ACT_LOOKUP, '0, '0, 1, ST_DONE, 1, '1, 0, 2);
        directed[7]  = stim_row(ACT_INSERT, '0, 32'd5, 1, ST_DONE, 0, '0, 0, 3);
        directed[8]  = stim_row(ACT_LOOKUP, '0, '0, 1, ST_DONE, 1, '1, 0, 3);
        directed[9]  = stim_row(ACT_COUNT, '0, '1, 1, ST_DONE, 0, '0, 1, 3);
        directed[10] = stim_row(ACT_COUNT, '0, '0, 1, ST_DONE, 0, '0, 1, 3);
        directed[11] = stim_row(ACT_RSVD_FIRST, '1, '1, 1, ST_DONE, 0, '0, 0, 3);
        directed[12] = stim_row(ACT_RSVD_MID, '0, '1, 1, ST_DONE, 0, '0, 0, 3);
        directed[13] = stim_row(ACT_RSVD_LAST, '1, '0, 1, ST_DONE, 0, '0, 0, 3);
        directed[14] = stim_row(ACT_ERASE, '0, '0, 1, ST_DONE, 1, '0, 0, 2);
        directed[15] = stim_row(ACT_LOOKUP, '0, '1, 1, ST_DONE, 1, 32'd5, 0, 2);
        directed[16] = stim_row(ACT_ERASE, 32'h1234_5678, '0, 1, ST_MISSING, 0, '0, 0, 2);
        directed[17] = stim_row(ACT_CLEAR, '1, '1, 1, ST_DONE, 0, '0, 0, 0);
        directed[18] = stim_row(ACT_LOOKUP, '1, '0, 1, ST_MISSING, 0, '0, 0, 0);
        directed[19] = stim_row(ACT_COUNT, '0, '1, 1, ST_DONE, 0, '0, 0, 0);
        directed[20] = stim_row(ACT_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, ST_DONE, 0, '0, 0, 0);
        directed[21] = stim_row(ACT_COUNT, '0, 32'h5A5A_5A5A, 0, ST_DONE, 0, '0, 0, 0);

        // small pools so that lookups, erases and counts often hit
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
        val_pool[0] = '0;
        val_pool[1] = '1;
        for (int i = 2; i < 6; i++) val_pool[i] = $urandom();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_item(directed[n]);
            sender_gap();
        end

        mix = MIX_FILL;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > 0 && n % PHASE_LEN == 0) begin
                mix = t_mix'($urandom_range(0, 2));
            end
            if (n >= N_RANDOM - CALM_TAIL) calm = 1'b1;
            pick  = $urandom_range(0, 99);
            s     = '0;
            s.key = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
            s.val = ($urandom_range(0, 4) == 0) ? $urandom() : val_pool[$urandom_range(0, 5)];
            case (mix)
                MIX_FILL:  s.act = (pick < 75) ? ACT_INSERT : (pick < 80) ? ACT_ERASE :
                                   (pick < 88) ? ACT_LOOKUP : (pick < 96) ? ACT_COUNT :
                                   (pick < 97) ? ACT_CLEAR :
                                   3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
                MIX_DRAIN: s.act = (pick < 15) ? ACT_INSERT : (pick < 60) ? ACT_ERASE :
                                   (pick < 78) ? ACT_LOOKUP : (pick < 93) ? ACT_COUNT :
                                   (pick < 95) ? ACT_CLEAR :
                                   3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
                default:   s.act = (pick < 35) ? ACT_INSERT : (pick < 55) ? ACT_ERASE :
                                   (pick < 75) ? ACT_LOOKUP : (pick < 92) ? ACT_COUNT :
                                   (pick < 95) ? ACT_CLEAR :
                                   3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
            endcase
            send_item(s);
            sender_gap();
        end
        calm = 1'b1;
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hdl/kvt_pkg.sv
hdl/kvt_mem.sv
hdl/keyed_value_table.sv
hdl/kvt_checker.sv
sim/keyed_value_table_tb.sv
